>>> rtl/core/assert_macros.svh
// Shared assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/amr_pkg.sv
package amr_pkg;

    localparam int FLAG_W  = 32;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;
    localparam int DWELL_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 1'd1;

    localparam logic [COUNT_W-1:0] ALARM_COUNT_RESET = 6'd32;
    localparam logic [DWELL_W-1:0] DWELL_TICKS_RESET = 16'd1000;

    typedef struct packed {
        logic              enable;
        logic [FLAG_W-1:0] alarm_flags;
    } t_in;

    typedef struct packed {
        logic [INDEX_W-1:0] message_index;
        logic               message_shown;
    } t_out;

endpackage

>>> rtl/core/alarm_message_rotator_core.sv
// Channel | Direction | Handshake                   | Beat
// input   | in        | i_in_valid / o_in_ready     | t_in: enable, alarm_flags
// result  | out       | o_out_valid / i_out_ready   | t_out: message_index, message_shown
// config  | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One beat is accepted per cycle while the result is not stalled. The state update
// (masked rotating priority search and dwell timer) is combinational and lies
// between the input and result registers.
// Synchronous active-low reset clears the state and valid flags and presets the config.
// A stalled result holds the input stage, which in turn drops o_in_ready.
`include "assert_macros.svh"

module alarm_message_rotator_core
    import amr_pkg::*;
#(
    parameter int ALARM_SLOTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOTS_USED = (ALARM_SLOTS < FLAG_W) ? ALARM_SLOTS : FLAG_W;
    localparam logic [COUNT_W-1:0] SLOTS_MAX = COUNT_W'(SLOTS_USED);

    logic [COUNT_W-1:0] r_alarm_count;
    logic [DWELL_W-1:0] r_dwell_ticks;

    logic               r_showing;
    logic [INDEX_W-1:0] r_cur;
    logic [DWELL_W-1:0] r_dwell;

    logic               r_in_valid;
    t_in                r_in;
    logic               r_out_valid;
    t_out               r_out;

    logic               n_showing;
    logic [INDEX_W-1:0] n_cur;
    logic [DWELL_W-1:0] n_dwell;

    logic               advance;
    logic [COUNT_W-1:0] count_use;
    logic [FLAG_W-1:0]  use_mask;
    logic [FLAG_W-1:0]  masked;
    logic [COUNT_W-1:0] start_wide;
    logic [INDEX_W-1:0] start;
    logic [FLAG_W-1:0]  upper;
    logic [FLAG_W-1:0]  pick_src;
    logic               any_set;
    logic [INDEX_W-1:0] found;
    logic [DWELL_W-1:0] dwell_dec;

    function automatic logic [INDEX_W-1:0] lowest_set(input logic [FLAG_W-1:0] v);
        logic [FLAG_W-1:0]  one_hot;
        logic [INDEX_W-1:0] idx;
        one_hot = v & (~v + FLAG_W'(1));
        idx = '0;
        for (int i = 0; i < FLAG_W; i++) begin
            if (one_hot[i]) begin
                idx = idx | INDEX_W'(i);
            end
        end
        return idx;
    endfunction

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        count_use = (r_alarm_count > SLOTS_MAX) ? SLOTS_MAX : r_alarm_count;
        if (count_use >= COUNT_W'(FLAG_W)) begin
            use_mask = '1;
        end else begin
            use_mask = (FLAG_W'(1) << count_use[INDEX_W-1:0]) - FLAG_W'(1);
        end
        masked = r_in.alarm_flags & use_mask;

        start_wide = r_showing ? (COUNT_W'(r_cur) + COUNT_W'(1)) : '0;
        start = (start_wide >= count_use) ? '0 : start_wide[INDEX_W-1:0];

        upper    = masked & ~((FLAG_W'(1) << start) - FLAG_W'(1));
        pick_src = (upper != '0) ? upper : masked;
        any_set  = (masked != '0);
        found    = lowest_set(pick_src);

        dwell_dec = (r_dwell != '0) ? (r_dwell - DWELL_W'(1)) : r_dwell;

        n_showing = r_showing;
        n_cur     = r_cur;
        n_dwell   = dwell_dec;
        if (!r_in.enable) begin
            n_showing = 1'b0;
            n_cur     = '0;
        end else if (r_showing && dwell_dec != '0 && masked[r_cur]) begin
            n_showing = 1'b1;
        end else if (any_set) begin
            n_showing = 1'b1;
            n_cur     = found;
            n_dwell   = r_dwell_ticks;
        end else if (r_showing) begin
            n_showing = 1'b0;
            n_cur     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_count <= ALARM_COUNT_RESET;
            r_dwell_ticks <= DWELL_TICKS_RESET;
            r_showing     <= 1'b0;
            r_cur         <= '0;
            r_dwell       <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ALARM_COUNT: r_alarm_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_DWELL_TICKS: r_dwell_ticks <= i_cfg_data[DWELL_W-1:0];
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_showing   <= n_showing;
                r_cur       <= n_cur;
                r_dwell     <= n_dwell;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out.message_index <= n_showing ? n_cur : '0;
            r_out.message_shown <= n_showing;
        end
    end

    `ASSERT_IMPLIES(a_hidden_index_zero, i_clk, i_rst_n, o_out_valid && !o_out.message_shown, o_out.message_index == '0)
    `ASSERT_IMPLIES(a_idle_index_zero, i_clk, i_rst_n, !r_showing, r_cur == '0)
    `ASSERT_NEXT(a_disable_hides, i_clk, i_rst_n, advance && !r_in.enable, !r_showing && !o_out.message_shown)
    `ASSERT_NEXT(a_result_follows_state, i_clk, i_rst_n, advance, o_out.message_shown == r_showing)

endmodule
